/* rtl/core/pcu_pkg.sv */
// Shared types and constants of the polygon centroid unit.
package pcu_pkg;

  // Fixed field and datapath widths.
  localparam int unsigned CoordW    = 16;
  localparam int unsigned CountW    = 11;
  localparam int unsigned ProdW     = 32;
  localparam int unsigned EdgeW     = 33;
  localparam int unsigned SumW      = 17;
  localparam int unsigned MomProdW  = SumW + EdgeW;
  localparam int unsigned AreaW     = 43;
  localparam int unsigned AreaOutW  = 42;
  localparam int unsigned MomW      = 58;
  localparam int unsigned DenW      = 45;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned InDataW   = 32;
  localparam int unsigned OutDataW  = 88;
  localparam int unsigned QueueDepth = 4;

  // Kind of a queued edge word.
  typedef enum logic {
    KIND_EDGE,
    KIND_FINISH
  } pcu_kind_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ZERO_AREA = 2'd1,
    STATUS_DROPPED   = 2'd2,
    STATUS_SATURATED = 2'd3
  } pcu_status_e;

  // Divider sequencer states.
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } pcu_div_state_e;

  // One edge handed from the front end to the back end.
  typedef struct packed {
    pcu_kind_e               kind;
    logic [CoordW-1:0]       x0;
    logic [CoordW-1:0]       y0;
    logic [CoordW-1:0]       x1;
    logic [CoordW-1:0]       y1;
    logic [CountW-1:0]       count;
    logic                    dropped;
  } pcu_edge_t;

  // Divider control from the back end.
  typedef struct packed {
    logic start;
    logic ack;
  } pcu_div_ctl_t;

  // Divider results and status.
  typedef struct packed {
    logic            busy;
    logic            done;
    logic [MomW-1:0] qx_mag;
    logic [MomW-1:0] qy_mag;
    logic            neg_x;
    logic            neg_y;
  } pcu_div_res_t;

endpackage

/* rtl/core/pcu_front.sv */
// Front end: accepts vertices, tracks the first and previous vertex and queues edges.
module pcu_front #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned COORD_WIDTH  = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_valid_i,
  output logic                       s_ready_o,
  input  logic [pcu_pkg::CoordW-1:0] vertex_x_i,
  input  logic [pcu_pkg::CoordW-1:0] vertex_y_i,
  input  logic                       last_i,
  input  logic                       full_i,
  output logic                       push_o,
  output pcu_pkg::pcu_edge_t         entry_o
);
  import pcu_pkg::*;

  localparam int unsigned ExtW = CoordW - COORD_WIDTH;
  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_VERTICES);

  logic signed [CoordW-1:0] x_sh, y_sh, x_ext, y_ext;
  logic [CoordW-1:0] first_x_q, first_x_d, first_y_q, first_y_d;
  logic [CoordW-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic [CountW-1:0] count_q, count_d;
  logic              ovf_q, ovf_d;
  logic              pend_q, pend_d;
  pcu_edge_t         pend_entry_q, pend_entry_d;
  pcu_edge_t         edge_entry;
  logic              accept, drop, edge_push;

  // Take the low COORD_WIDTH bits of each coordinate as two's complement.
  assign x_sh  = vertex_x_i << ExtW;
  assign y_sh  = vertex_y_i << ExtW;
  assign x_ext = x_sh >>> ExtW;
  assign y_ext = y_sh >>> ExtW;

  assign s_ready_o = !pend_q && !full_i;
  assign accept    = s_valid_i && s_ready_o;
  assign drop      = (count_q >= MaxCount);
  assign edge_push = accept && !drop && (count_q != '0);

  // Edge from the previous vertex to the new one.
  always_comb begin
    edge_entry         = '0;
    edge_entry.kind    = KIND_EDGE;
    edge_entry.x0      = prev_x_q;
    edge_entry.y0      = prev_y_q;
    edge_entry.x1      = x_ext;
    edge_entry.y1      = y_ext;
    edge_entry.count   = count_q;
    edge_entry.dropped = ovf_q;
  end

  assign push_o  = edge_push || (pend_q && !full_i);
  assign entry_o = pend_q ? pend_entry_q : edge_entry;

  // Polygon state update; the final vertex leaves a closing word pending.
  always_comb begin
    first_x_d    = first_x_q;
    first_y_d    = first_y_q;
    prev_x_d     = prev_x_q;
    prev_y_d     = prev_y_q;
    count_d      = count_q;
    ovf_d        = ovf_q;
    pend_d       = pend_q;
    pend_entry_d = pend_entry_q;
    if (pend_q && !full_i) begin
      pend_d = 1'b0;
    end
    if (accept) begin
      if (drop) begin
        ovf_d = 1'b1;
      end else begin
        if (count_q == '0) begin
          first_x_d = x_ext;
          first_y_d = y_ext;
        end
        prev_x_d = x_ext;
        prev_y_d = y_ext;
        count_d  = count_q + 1'b1;
      end
      if (last_i) begin
        pend_d               = 1'b1;
        pend_entry_d.kind    = KIND_FINISH;
        pend_entry_d.x0      = prev_x_d;
        pend_entry_d.y0      = prev_y_d;
        pend_entry_d.x1      = first_x_d;
        pend_entry_d.y1      = first_y_d;
        pend_entry_d.count   = count_d;
        pend_entry_d.dropped = ovf_d;
        first_x_d = '0;
        first_y_d = '0;
        prev_x_d  = '0;
        prev_y_d  = '0;
        count_d   = '0;
        ovf_d     = 1'b0;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      first_x_q <= first_x_d;
      first_y_q <= first_y_d;
      prev_x_q  <= prev_x_d;
      prev_y_q  <= prev_y_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      pend_q    <= pend_d;
    end
  end

  // Pending closing word needs no reset.
  always_ff @(posedge clk_i) begin
    pend_entry_q <= pend_entry_d;
  end

`ifndef NO_ASSERTIONS
  // A final vertex always returns the polygon count to zero.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_i) |=> (count_q == '0))
    else $error("vertex count not cleared after final vertex");
`endif

endmodule

/* rtl/core/pcu_fifo.sv */
// Short queue of edge words between the front end and the back end.
module pcu_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pcu_pkg::pcu_edge_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output pcu_pkg::pcu_edge_t data_o
);
  import pcu_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  pcu_edge_t         mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   fill_q;

  assign full_o  = (fill_q == CntW'(QueueDepth));
  assign valid_o = (fill_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (!push_i && pop_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef NO_ASSERTIONS
  // The front end never writes into a full queue.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("edge queue overrun");

  // The back end never reads an empty queue.
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("edge queue underrun");
`endif

endmodule

/* rtl/core/pcu_div.sv */
// Two-lane restoring divider, one quotient bit per lane and cycle.
module pcu_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pcu_pkg::pcu_div_ctl_t     ctl_i,
  input  logic [pcu_pkg::MomW-1:0]  num_x_i,
  input  logic [pcu_pkg::MomW-1:0]  num_y_i,
  input  logic [pcu_pkg::DenW-1:0]  den_i,
  output pcu_pkg::pcu_div_res_t     res_o
);
  import pcu_pkg::*;

  localparam int unsigned StepW = $clog2(MomW);

  pcu_div_state_e   state_q, state_d;
  logic [StepW-1:0] step_q;
  logic [MomW-1:0]  nx_q, ny_q;
  logic [DenW-1:0]  rx_q, ry_q, dv_q;
  logic             neg_x_q, neg_y_q;
  logic [DenW+MomW-1:0] step_x, step_y;
  logic [MomW-1:0]  abs_x, abs_y;
  logic [DenW-1:0]  abs_d;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  function automatic logic [DenW+MomW-1:0] div_step(logic [DenW-1:0] rem,
                                                    logic [MomW-1:0] num,
                                                    logic [DenW-1:0] dv);
    logic [DenW:0] trial;
    logic [DenW:0] diff;
    logic          ge;
    trial = {rem, num[MomW-1]};
    diff  = trial - {1'b0, dv};
    ge    = (trial >= {1'b0, dv});
    return {(ge ? diff[DenW-1:0] : trial[DenW-1:0]), num[MomW-2:0], ge};
  endfunction

  assign abs_x  = num_x_i[MomW-1] ? (~num_x_i + 1'b1) : num_x_i;
  assign abs_y  = num_y_i[MomW-1] ? (~num_y_i + 1'b1) : num_y_i;
  assign abs_d  = den_i[DenW-1] ? (~den_i + 1'b1) : den_i;
  assign step_x = div_step(rx_q, nx_q, dv_q);
  assign step_y = div_step(ry_q, ny_q, dv_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      DIV_IDLE: begin
        if (ctl_i.start) begin
          state_d = DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (step_q == StepW'(MomW - 1)) begin
          state_d = DIV_DONE;
        end
      end
      DIV_DONE: begin
        if (ctl_i.ack) begin
          state_d = DIV_IDLE;
        end
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    res_o.busy   = 1'b0;
    res_o.done   = 1'b0;
    res_o.qx_mag = nx_q;
    res_o.qy_mag = ny_q;
    res_o.neg_x  = neg_x_q;
    res_o.neg_y  = neg_y_q;
    case (state_q)
      DIV_RUN:  res_o.busy = 1'b1;
      DIV_DONE: res_o.done = 1'b1;
      default:  res_o.busy = 1'b0;
    endcase
  end

  // Sequencer state and step count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == DIV_RUN) begin
        step_q <= step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
    end
  end

  // Operand load and iteration.
  always_ff @(posedge clk_i) begin
    if ((state_q == DIV_IDLE) && ctl_i.start) begin
      nx_q    <= abs_x;
      ny_q    <= abs_y;
      dv_q    <= abs_d;
      rx_q    <= '0;
      ry_q    <= '0;
      neg_x_q <= num_x_i[MomW-1] ^ den_i[DenW-1];
      neg_y_q <= num_y_i[MomW-1] ^ den_i[DenW-1];
    end else if (state_q == DIV_RUN) begin
      rx_q <= step_x[DenW+MomW-1:MomW];
      nx_q <= step_x[MomW-1:0];
      ry_q <= step_y[DenW+MomW-1:MomW];
      ny_q <= step_y[MomW-1:0];
    end
  end

endmodule

/* rtl/core/pcu_back.sv */
// Back end: edge accumulation pipeline, final divide and result register.
module pcu_back #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  pcu_pkg::pcu_edge_t            q_entry_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pcu_pkg::CoordW-1:0]    centroid_x_o,
  output logic [pcu_pkg::CoordW-1:0]    centroid_y_o,
  output logic [pcu_pkg::AreaOutW-1:0]  area_twice_o,
  output logic [pcu_pkg::CountW-1:0]    vertex_count_o,
  output pcu_pkg::pcu_status_e          status_o
);
  import pcu_pkg::*;

  localparam logic [MomW-1:0] HiMag = MomW'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
  localparam logic [MomW-1:0] LoMag = MomW'(64'd1 << (COORD_WIDTH - 1));
  localparam logic [AreaOutW-1:0] AreaMax = {1'b0, {(AreaOutW - 1){1'b1}}};
  localparam logic [AreaOutW-1:0] AreaMin = {1'b1, {(AreaOutW - 1){1'b0}}};

  logic hold_q, hold_d;

  // Stage one: cross products and coordinate sums.
  logic                      v1_q;
  pcu_kind_e                 kind1_q;
  logic signed [ProdW-1:0]   p1_q, p2_q, p1, p2;
  logic signed [SumW-1:0]    sx1_q, sy1_q;
  logic [CountW-1:0]         cnt1_q;
  logic                      drop1_q;

  // Stage two: edge term and area sum.
  logic                      v2_q;
  pcu_kind_e                 kind2_q;
  logic signed [EdgeW-1:0]   a2_q, a1;
  logic signed [SumW-1:0]    sx2_q, sy2_q;
  logic [CountW-1:0]         cnt2_q;
  logic                      drop2_q;

  // Stage three: moment sums.
  logic signed [MomProdW-1:0] mx_prod, my_prod;
  logic                       fin3_q;
  logic [CountW-1:0]          cnt3_q;
  logic                       drop3_q;

  logic [AreaW-1:0]  area_q;
  logic [MomW-1:0]   mx_q, my_q;
  logic [DenW-1:0]   den;

  // Values held for the result while the divider runs.
  logic [AreaW-1:0]  area_fin_q;
  logic [CountW-1:0] cnt_fin_q;
  logic              drop_fin_q;

  pcu_div_ctl_t div_ctl;
  pcu_div_res_t div_res;

  logic              out_load, zero_area, sat_x, sat_y;
  logic [CoordW-1:0] cx, cy;
  logic [AreaOutW-1:0] area_out;
  pcu_status_e       status;
  logic              out_valid_q;

  // Saturate one quotient lane into the coordinate range; MSB of result is the flag.
  function automatic logic [CoordW:0] sat_lane(logic [MomW-1:0] mag, logic neg);
    logic [CoordW:0] r;
    if (neg) begin
      if (mag > LoMag) begin
        r = {1'b1, (~LoMag[CoordW-1:0] + 1'b1)};
      end else begin
        r = {1'b0, (~mag[CoordW-1:0] + 1'b1)};
      end
    end else begin
      if (mag > HiMag) begin
        r = {1'b1, HiMag[CoordW-1:0]};
      end else begin
        r = {1'b0, mag[CoordW-1:0]};
      end
    end
    return r;
  endfunction

  // Queue read: stop after a closing word until its result is out.
  assign q_pop_o = q_valid_i && !hold_q;

  always_comb begin
    hold_d = hold_q;
    if (q_pop_o && (q_entry_i.kind == KIND_FINISH)) begin
      hold_d = 1'b1;
    end else if (div_ctl.ack) begin
      hold_d = 1'b0;
    end
  end

  assign p1 = $signed(q_entry_i.x0) * $signed(q_entry_i.y1);
  assign p2 = $signed(q_entry_i.x1) * $signed(q_entry_i.y0);
  assign a1 = $signed({p1_q[ProdW-1], p1_q}) - $signed({p2_q[ProdW-1], p2_q});
  assign mx_prod = sx2_q * a2_q;
  assign my_prod = sy2_q * a2_q;
  assign den = {{(DenW - AreaW){area_q[AreaW-1]}}, area_q}
             + {{(DenW - AreaW - 1){area_q[AreaW-1]}}, area_q, 1'b0};

  // Divider hookup.
  assign div_ctl.start = fin3_q;
  assign out_load      = div_res.done && (!out_valid_q || out_ready_i);
  assign div_ctl.ack   = out_load;

  pcu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (div_ctl),
    .num_x_i (mx_q),
    .num_y_i (my_q),
    .den_i   (den),
    .res_o   (div_res)
  );

  // Result formatting and status priority.
  always_comb begin
    logic [CoordW:0] lx;
    logic [CoordW:0] ly;
    lx        = sat_lane(div_res.qx_mag, div_res.neg_x);
    ly        = sat_lane(div_res.qy_mag, div_res.neg_y);
    zero_area = (area_fin_q == '0);
    sat_x     = lx[CoordW];
    sat_y     = ly[CoordW];
    cx        = zero_area ? '0 : lx[CoordW-1:0];
    cy        = zero_area ? '0 : ly[CoordW-1:0];
    if (zero_area) begin
      status = STATUS_ZERO_AREA;
    end else if (drop_fin_q) begin
      status = STATUS_DROPPED;
    end else if (sat_x || sat_y) begin
      status = STATUS_SATURATED;
    end else begin
      status = STATUS_OK;
    end
    if (area_fin_q[AreaW-1] != area_fin_q[AreaW-2]) begin
      area_out = area_fin_q[AreaW-1] ? AreaMin : AreaMax;
    end else begin
      area_out = area_fin_q[AreaOutW-1:0];
    end
  end

  // Control and accumulator registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q      <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      fin3_q      <= 1'b0;
      out_valid_q <= 1'b0;
      area_q      <= '0;
      mx_q        <= '0;
      my_q        <= '0;
    end else begin
      hold_q <= hold_d;
      v1_q   <= q_pop_o;
      v2_q   <= v1_q;
      fin3_q <= v2_q && (kind2_q == KIND_FINISH);
      if (fin3_q) begin
        area_q <= '0;
        mx_q   <= '0;
        my_q   <= '0;
      end else begin
        if (v1_q) begin
          area_q <= area_q + {{(AreaW - EdgeW){a1[EdgeW-1]}}, a1};
        end
        if (v2_q) begin
          mx_q <= mx_q + {{(MomW - MomProdW){mx_prod[MomProdW-1]}}, mx_prod};
          my_q <= my_q + {{(MomW - MomProdW){my_prod[MomProdW-1]}}, my_prod};
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Pipeline payload and result register.
  always_ff @(posedge clk_i) begin
    kind1_q <= q_entry_i.kind;
    p1_q    <= p1;
    p2_q    <= p2;
    sx1_q   <= $signed({q_entry_i.x0[CoordW-1], q_entry_i.x0}
                     + {q_entry_i.x1[CoordW-1], q_entry_i.x1});
    sy1_q   <= $signed({q_entry_i.y0[CoordW-1], q_entry_i.y0}
                     + {q_entry_i.y1[CoordW-1], q_entry_i.y1});
    cnt1_q  <= q_entry_i.count;
    drop1_q <= q_entry_i.dropped;
    kind2_q <= kind1_q;
    a2_q    <= a1;
    sx2_q   <= sx1_q;
    sy2_q   <= sy1_q;
    cnt2_q  <= cnt1_q;
    drop2_q <= drop1_q;
    cnt3_q  <= cnt2_q;
    drop3_q <= drop2_q;
    if (fin3_q) begin
      area_fin_q <= area_q;
      cnt_fin_q  <= cnt3_q;
      drop_fin_q <= drop3_q;
    end
    if (out_load) begin
      centroid_x_o   <= cx;
      centroid_y_o   <= cy;
      area_twice_o   <= area_out;
      vertex_count_o <= cnt_fin_q;
      status_o       <= status;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/core/polygon_centroid_unit.sv */
// Top level of the polygon centroid unit.
//
// Vertices enter on the s_axis word channel: tdata carries x and y, tlast
// marks the vertex that closes the polygon. Each polygon gives one result
// word on m_axis: the centroid, twice the signed area, the vertex count
// and a status code in tuser.
// The vertex that closes a polygon holds the input while its closing edge
// is queued. Edges run through a three-stage multiply and accumulate
// pipeline, one per cycle while the queue is not held after a closing word.
// The centroid divide is a restoring divider with one quotient bit per
// cycle over the 58-bit moment sums; polygon rate is set by that divider.
// Meanwhile the edge queue, QueueDepth words deep, takes in edges of the
// next polygon until it is full, and then the input stalls.
// Reset clears all polygon state and empties the queue and output register.
// A result waits in the output register while m_axis_tready is low; the
// divider holds its quotient, and input stalls once the queue is full.
module polygon_centroid_unit #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned COORD_WIDTH  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [15:0] vertex_x, [31:16] vertex_y
  input  logic [pcu_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [15:0] centroid_x, [31:16] centroid_y, [73:32] area_twice,
  // [84:74] vertex_count, [87:85] zero
  output logic [pcu_pkg::OutDataW-1:0] m_axis_tdata,
  // [1:0] status
  output logic [pcu_pkg::StatusW-1:0]  m_axis_tuser
);
  import pcu_pkg::*;

  logic        q_full, q_push, q_pop, q_valid;
  pcu_edge_t   q_wr, q_rd;
  logic [CoordW-1:0]   cx, cy;
  logic [AreaOutW-1:0] area;
  logic [CountW-1:0]   cnt;
  pcu_status_e         status;

  // Vertex intake.
  pcu_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .vertex_x_i (s_axis_tdata[CoordW-1:0]),
    .vertex_y_i (s_axis_tdata[2*CoordW-1:CoordW]),
    .last_i     (s_axis_tlast),
    .full_i     (q_full),
    .push_o     (q_push),
    .entry_o    (q_wr)
  );

  // Edge queue.
  pcu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wr),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rd)
  );

  // Accumulation, divide and result register.
  pcu_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_pop_o        (q_pop),
    .q_entry_i      (q_rd),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .centroid_x_o   (cx),
    .centroid_y_o   (cy),
    .area_twice_o   (area),
    .vertex_count_o (cnt),
    .status_o       (status)
  );

  // Result word packing.
  assign m_axis_tdata = {3'b000, cnt, area, cy, cx};
  assign m_axis_tuser = status;

`ifndef NO_ASSERTIONS
  // A zero-area result carries a zero centroid.
  a_zero_area_centroid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (status == STATUS_ZERO_AREA)) |-> ((cx == '0) && (cy == '0)))
    else $error("zero-area result with nonzero centroid");
`endif

endmodule
